@@ rtl/ansi_sgr_color_parser_top_macros.svh @@
// Assertion macros shared by the color parser modules.
// Each checker samples on i_clk; the guarded form is off while i_rst_n is low.
`ifndef ANSI_SGR_COLOR_PARSER_TOP_MACROS_SVH
`define ANSI_SGR_COLOR_PARSER_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASGR_CHECK(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) expr) else $error(msg);
`define ASGR_CHECK_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) expr) else $error(msg);
`else
`define ASGR_CHECK(lbl, expr, msg)
`define ASGR_CHECK_ALWAYS(lbl, expr, msg)
`endif
`endif

@@ rtl/asgr_pkg.sv @@
`timescale 1ns / 1ps

package asgr_pkg;

    // Byte codes that steer the parser.
    localparam logic [7:0] CH_ESC      = 8'h1B;
    localparam logic [7:0] CH_LBRACKET = 8'h5B;
    localparam logic [7:0] CH_SEMI     = 8'h3B;
    localparam logic [7:0] CH_M        = 8'h6D;
    localparam logic [7:0] CH_ZERO     = 8'h30;
    localparam logic [7:0] CH_NINE     = 8'h39;

    // Attribute loaded at reset: low nibble foreground, high nibble background.
    localparam logic [7:0] RESET_ATTR = 8'h07;

    // Queue between front and back.
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    // Result kinds.
    localparam logic KIND_PRINT = 1'b0;
    localparam logic KIND_SET   = 1'b1;

    typedef enum logic [2:0] {
        CLS_OTHER    = 3'd0,
        CLS_ESC      = 3'd1,
        CLS_LBRACKET = 3'd2,
        CLS_DIGIT    = 3'd3,
        CLS_SEMI     = 3'd4,
        CLS_MARK_M   = 3'd5
    } t_cls;

    typedef struct packed {
        t_cls       cls;
        logic [7:0] data;
    } t_item;

    typedef struct packed {
        logic [3:0] bg;
        logic [3:0] fg;
    } t_colors;

    function automatic t_cls classify(input logic [7:0] b);
        t_cls c;
        c = CLS_OTHER;
        if (b == CH_ESC) begin
            c = CLS_ESC;
        end else if (b == CH_LBRACKET) begin
            c = CLS_LBRACKET;
        end else if (b inside {[CH_ZERO:CH_NINE]}) begin
            c = CLS_DIGIT;
        end else if (b == CH_SEMI) begin
            c = CLS_SEMI;
        end else if (b == CH_M) begin
            c = CLS_MARK_M;
        end
        return c;
    endfunction

    // Applies one SGR code to the pending pair; unmapped codes leave it alone.
    function automatic t_colors apply_code(input logic [7:0] code, input t_colors pend);
        t_colors r;
        r = pend;
        if (code inside {[8'd30:8'd37]}) begin
            r.fg = 4'(code - 8'd30);
        end else if (code inside {[8'd90:8'd97]}) begin
            r.fg = 4'(code - 8'd82);
        end else if (code inside {[8'd40:8'd47]}) begin
            r.bg = 4'(code - 8'd40);
        end else if (code inside {[8'd100:8'd107]}) begin
            r.bg = 4'(code - 8'd92);
        end
        return r;
    endfunction

    // Decimal accumulate with saturation at 255.
    function automatic logic [7:0] accum_digit(input logic [7:0] acc, input logic [3:0] d);
        logic [11:0] v;
        v = ({4'd0, acc} << 3) + ({4'd0, acc} << 1) + {8'd0, d};
        return (v > 12'd255) ? 8'hFF : v[7:0];
    endfunction

endpackage

@@ rtl/asgr_front.sv @@
`timescale 1ns / 1ps

module asgr_front (
    input  logic             i_in_valid,
    input  logic [7:0]       i_text_byte,
    input  logic             i_q_full,
    output logic             o_in_stall,
    output logic             o_push,
    output asgr_pkg::t_item  o_item
);

    // The front takes a beat whenever the queue has room and tags its class.
    assign o_in_stall  = i_q_full;
    assign o_push      = i_in_valid && !i_q_full;
    assign o_item.cls  = asgr_pkg::classify(i_text_byte);
    assign o_item.data = i_text_byte;

endmodule

@@ rtl/asgr_queue.sv @@
`timescale 1ns / 1ps
`include "ansi_sgr_color_parser_top_macros.svh"

module asgr_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  asgr_pkg::t_item  i_item,
    input  logic             i_pop,
    output asgr_pkg::t_item  o_item,
    output logic             o_valid,
    output logic             o_full
);

    asgr_pkg::t_item r_mem [asgr_pkg::Q_DEPTH];

    logic [asgr_pkg::Q_AW-1:0] r_wr_ptr, n_wr_ptr;
    logic [asgr_pkg::Q_AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [asgr_pkg::Q_CW-1:0] r_count, n_count;

    localparam logic [asgr_pkg::Q_CW-1:0] FULL_COUNT = asgr_pkg::Q_CW'(asgr_pkg::Q_DEPTH);
    localparam logic [asgr_pkg::Q_AW-1:0] LAST_PTR   = asgr_pkg::Q_AW'(asgr_pkg::Q_DEPTH - 1);

    assign o_valid = (r_count != '0);
    assign o_full  = (r_count == FULL_COUNT);
    assign o_item  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    `ASGR_CHECK(a_count_bound, r_count <= FULL_COUNT, "queue count above depth")
    `ASGR_CHECK(a_no_pop_empty, !(i_pop && r_count == '0), "pop from empty queue")
    `ASGR_CHECK(a_count_up, (i_push && !i_pop) |=> (r_count == $past(r_count) + 1'b1),
        "queue count did not follow a push")

endmodule

@@ rtl/asgr_back.sv @@
`timescale 1ns / 1ps
`include "ansi_sgr_color_parser_top_macros.svh"

module asgr_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [7:0]       i_cfg_wdata,
    input  logic             i_q_valid,
    input  asgr_pkg::t_item  i_item,
    output logic             o_pop,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output logic             o_result_kind,
    output logic [7:0]       o_out_char,
    output logic [3:0]       o_fg_color,
    output logic [3:0]       o_bg_color
);

    typedef enum logic [2:0] {
        MODE_NORMAL = 3'b001,
        MODE_ESC    = 3'b010,
        MODE_SEQ    = 3'b100
    } t_mode;

    t_mode               r_mode, n_mode;
    logic [7:0]          r_acc, n_acc;
    logic                r_seen, n_seen;
    asgr_pkg::t_colors   r_pend, n_pend;
    asgr_pkg::t_colors   r_cur, n_cur;

    logic                r_out_valid;
    logic                r_kind;
    logic [7:0]          r_char;
    asgr_pkg::t_colors   r_out_col;

    logic                out_free;
    logic                emit;
    logic                n_kind;
    logic [7:0]          n_char;
    asgr_pkg::t_colors   applied;

    assign out_free = !r_out_valid || !i_out_stall;
    assign o_pop    = i_q_valid && out_free;
    assign applied  = asgr_pkg::apply_code(r_acc, r_pend);

    always_comb begin
        n_mode = r_mode;
        n_acc  = r_acc;
        n_seen = r_seen;
        n_pend = r_pend;
        n_cur  = r_cur;
        emit   = 1'b0;
        n_kind = asgr_pkg::KIND_PRINT;
        n_char = i_item.data;
        if (o_pop) begin
            case (r_mode)
                MODE_ESC: begin
                    if (i_item.cls == asgr_pkg::CLS_LBRACKET) begin
                        n_mode = MODE_SEQ;
                        n_acc  = '0;
                        n_seen = 1'b0;
                        n_pend = r_cur;
                    end else begin
                        n_mode = MODE_NORMAL;
                        emit   = 1'b1;
                    end
                end
                MODE_SEQ: begin
                    case (i_item.cls)
                        asgr_pkg::CLS_DIGIT: begin
                            n_acc  = asgr_pkg::accum_digit(r_acc, i_item.data[3:0]);
                            n_seen = 1'b1;
                        end
                        asgr_pkg::CLS_SEMI: begin
                            n_pend = applied;
                            n_acc  = '0;
                        end
                        asgr_pkg::CLS_MARK_M: begin
                            n_pend = applied;
                            n_acc  = '0;
                            n_mode = MODE_NORMAL;
                            if (r_seen) begin
                                n_seen = 1'b0;
                                n_cur  = applied;
                                emit   = 1'b1;
                                n_kind = asgr_pkg::KIND_SET;
                                n_char = '0;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                default: begin
                    if (i_item.cls == asgr_pkg::CLS_ESC) begin
                        n_mode = MODE_ESC;
                    end else begin
                        n_mode = MODE_NORMAL;
                        emit   = 1'b1;
                    end
                end
            endcase
        end
        if (i_cfg_we) begin
            n_cur  = i_cfg_wdata;
            n_pend = i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_NORMAL;
            r_acc       <= '0;
            r_seen      <= 1'b0;
            r_pend      <= asgr_pkg::RESET_ATTR;
            r_cur       <= asgr_pkg::RESET_ATTR;
            r_out_valid <= 1'b0;
        end else begin
            r_mode <= n_mode;
            r_acc  <= n_acc;
            r_seen <= n_seen;
            r_pend <= n_pend;
            r_cur  <= n_cur;
            if (out_free) begin
                r_out_valid <= emit;
            end
        end
    end

    // The result carries the colors after this beat's update.
    always_ff @(posedge i_clk) begin
        if (out_free && emit) begin
            r_kind    <= n_kind;
            r_char    <= n_char;
            r_out_col <= n_cur;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_result_kind = r_kind;
    assign o_out_char    = r_char;
    assign o_fg_color    = r_out_col.fg;
    assign o_bg_color    = r_out_col.bg;

    `ASGR_CHECK(a_open_seq,
        (o_pop && r_mode == MODE_ESC && i_item.cls == asgr_pkg::CLS_LBRACKET)
            |=> (r_mode == MODE_SEQ),
        "ESC [ did not open a sequence")
    `ASGR_CHECK(a_acc_sat,
        (o_pop && r_mode == MODE_SEQ && i_item.cls == asgr_pkg::CLS_DIGIT && r_acc == 8'hFF)
            |=> (r_acc == 8'hFF),
        "accumulator left saturation on a digit")
    `ASGR_CHECK(a_set_from_seq,
        (r_out_valid && r_kind == asgr_pkg::KIND_SET && !$past(r_out_valid && i_out_stall))
            |-> ($past(r_mode) == MODE_SEQ && r_char == 8'd0),
        "set-color result not issued from a sequence")

endmodule

@@ rtl/ansi_sgr_color_parser_top.sv @@
`timescale 1ns / 1ps

// ANSI SGR color parser. Text bytes arrive one beat at a time on the input
// channel; ordinary bytes come back as print results tagged with the colors in
// effect, and an ESC [ ... m sequence with at least one digit gives one
// set-color result carrying the new foreground and background. Sequences with
// no digits, the bytes inside sequences, and a lone ESC give no result. The
// block sustains one beat per clock cycle in both directions while the output
// does not stall; that figure is set by the back end, which applies one byte to
// the parser state and loads the output register in the same cycle. An accepted
// byte is registered in the four-beat queue that sits behind the classifying
// front end, and its result then in the output register. The queue lets the
// input keep flowing for up to four beats while the output stalls.
// Writing the configuration register loads the attribute into both the current
// and the pending colors; write it only while no accepted byte is still in
// flight.
module ansi_sgr_color_parser_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_wdata,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_text_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_result_kind,
    output logic [7:0]  o_out_char,
    output logic [3:0]  o_fg_color,
    output logic [3:0]  o_bg_color
);

    // Classified beats travel from the front end to the queue, then to the back end.
    asgr_pkg::t_item front_item;
    asgr_pkg::t_item head_item;
    logic            push;
    logic            pop;
    logic            q_valid;
    logic            q_full;

    // The front end stalls only when the queue is full.
    asgr_front u_front (
        .i_in_valid  (i_in_valid),
        .i_text_byte (i_text_byte),
        .i_q_full    (q_full),
        .o_in_stall  (o_in_stall),
        .o_push      (push),
        .o_item      (front_item)
    );

    asgr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .i_pop   (pop),
        .o_item  (head_item),
        .o_valid (q_valid),
        .o_full  (q_full)
    );

    // The back end pops a beat whenever its output register is free or draining.
    asgr_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_q_valid     (q_valid),
        .i_item        (head_item),
        .o_pop         (pop),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_result_kind (o_result_kind),
        .o_out_char    (o_out_char),
        .o_fg_color    (o_fg_color),
        .o_bg_color    (o_bg_color)
    );

endmodule

@@ dv/tb_ansi_sgr_color_parser_top.sv @@
`timescale 1ns / 1ps

// Self-checking bench for the ANSI SGR color parser. Bytes are queued by the
// stimulus process and driven one beat at a time. Every accepted beat is run
// through a cycle-free copy of the parser state kept in this module, and any
// result it produces is queued. Every accepted output beat is checked field by
// field against the oldest queued result.
module tb_ansi_sgr_color_parser_top;

    localparam logic [7:0] ATTR_AT_RESET = 8'h07;
    localparam int CYCLE_LIMIT = 400000;
    // Cycles to let the pipeline drain after the last result. This covers
    // bytes that are still in flight but produce no result.
    localparam int DRAIN_CYCLES = 12;
    localparam int LONG_HOLD_CYCLES = 80;

    // Bytes of the first phase: the extremes of the byte range, a full color
    // sequence, an ESC followed by ESC or NUL, a sequence with no digits, and
    // a sequence that carries ignored bytes and an overflowing, unmapped code.
    localparam logic [7:0] DIRECTED_BYTES [26] = '{
        8'h00, 8'hFF,
        asgr_pkg::CH_ESC, asgr_pkg::CH_LBRACKET, "3", "7", asgr_pkg::CH_SEMI,
        "1", "0", "0", asgr_pkg::CH_M,
        asgr_pkg::CH_ESC, asgr_pkg::CH_ESC,
        asgr_pkg::CH_ESC, 8'h00,
        asgr_pkg::CH_ESC, asgr_pkg::CH_LBRACKET, asgr_pkg::CH_M,
        asgr_pkg::CH_ESC, asgr_pkg::CH_LBRACKET, asgr_pkg::CH_ESC, 8'h00,
        "9", "9", "9", asgr_pkg::CH_M
    };

    typedef enum logic [1:0] {
        PM_TEXT,
        PM_ESC,
        PM_SEQ
    } t_parse_mode;

    typedef struct packed {
        logic       kind;
        logic [7:0] ch;
        logic [3:0] fg;
        logic [3:0] bg;
    } t_color_result;

    // Block ports. Every input starts at a known value.
    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_cfg_we = 1'b0;
    logic [7:0] i_cfg_wdata = 8'h00;
    logic       i_in_valid = 1'b0;
    logic       o_in_stall;
    logic [7:0] i_text_byte = 8'h00;
    logic       o_out_valid;
    logic       i_out_stall = 1'b0;
    logic       o_result_kind;
    logic [7:0] o_out_char;
    logic [3:0] o_fg_color;
    logic [3:0] o_bg_color;

    // Stimulus and scoreboard storage.
    logic [7:0]    send_bytes[$];
    t_color_result color_expect[$];
    int            mismatch_count = 0;
    int            cycle_count = 0;

    // Traffic shaping. The stimulus process sets idle_on and long_hold_req; the driver processes keep the rest.
    bit idle_on = 1'b1;
    bit long_hold_req = 1'b0;
    bit long_hold_ack = 1'b0;
    int send_gap = 0;
    int stall_left = 0;

    // Shadow copy of the parser state.
    t_parse_mode pmode;
    logic [7:0]  attr_reg;
    logic [7:0]  code_acc;
    logic        code_seen;
    logic [3:0]  pend_fg;
    logic [3:0]  pend_bg;
    logic [3:0]  cur_fg;
    logic [3:0]  cur_bg;

    ansi_sgr_color_parser_top uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_text_byte   (i_text_byte),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_result_kind (o_result_kind),
        .o_out_char    (o_out_char),
        .o_fg_color    (o_fg_color),
        .o_bg_color    (o_bg_color)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Prints one line per problem and keeps the tally that decides the verdict.
    task automatic report_mismatch(input string what, input int got, input int want);
        mismatch_count++;
        $display("ERROR at %0t ns: %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    endtask

    // Loading the attribute sets both the committed and the pending colors; the
    // parse mode, the accumulator and the digit flag keep their values.
    task automatic load_attr(input logic [7:0] attr);
        attr_reg = attr;
        cur_fg   = attr[3:0];
        cur_bg   = attr[7:4];
        pend_fg  = attr[3:0];
        pend_bg  = attr[7:4];
    endtask

    // Folds the accumulated code into the pending colors. Codes outside the
    // four color ranges change nothing, but the accumulator is always cleared.
    task automatic take_sgr_code();
        int c;
        c = int'(code_acc);
        if (c >= 30 && c <= 37) begin
            pend_fg = 4'(c - 30);
        end else if (c >= 90 && c <= 97) begin
            pend_fg = 4'(c - 90 + 8);
        end else if (c >= 40 && c <= 47) begin
            pend_bg = 4'(c - 40);
        end else if (c >= 100 && c <= 107) begin
            pend_bg = 4'(c - 100 + 8);
        end
        code_acc = 8'd0;
    endtask

    // Advances the shadow parser by one byte and says whether a result follows.
    task automatic predict_byte(input logic [7:0] b, output bit has, output t_color_result r);
        int v;
        has = 1'b0;
        r   = '0;
        case (pmode)
            PM_ESC: begin
                if (b == asgr_pkg::CH_LBRACKET) begin
                    pmode     = PM_SEQ;
                    code_acc  = 8'd0;
                    code_seen = 1'b0;
                    pend_fg   = cur_fg;
                    pend_bg   = cur_bg;
                end else begin
                    // The ESC is dropped and this byte goes out raw.
                    pmode = PM_TEXT;
                    has   = 1'b1;
                    r     = '{asgr_pkg::KIND_PRINT, b, cur_fg, cur_bg};
                end
            end
            PM_SEQ: begin
                if (b >= asgr_pkg::CH_ZERO && b <= asgr_pkg::CH_NINE) begin
                    v         = int'(code_acc) * 10 + int'(b) - int'(asgr_pkg::CH_ZERO);
                    code_acc  = (v > 255) ? 8'd255 : 8'(v);
                    code_seen = 1'b1;
                end else if (b == asgr_pkg::CH_SEMI) begin
                    take_sgr_code();
                end else if (b == asgr_pkg::CH_M) begin
                    take_sgr_code();
                    pmode = PM_TEXT;
                    // A sequence without digits closes silently.
                    if (code_seen) begin
                        code_seen = 1'b0;
                        cur_fg    = pend_fg;
                        cur_bg    = pend_bg;
                        has       = 1'b1;
                        r         = '{asgr_pkg::KIND_SET, 8'h00, cur_fg, cur_bg};
                    end
                end
            end
            default: begin
                pmode = PM_TEXT;
                if (b == asgr_pkg::CH_ESC) begin
                    pmode = PM_ESC;
                end else begin
                    has = 1'b1;
                    r   = '{asgr_pkg::KIND_PRINT, b, cur_fg, cur_bg};
                end
            end
        endcase
    endtask

    // Input driver. A beat stays on the bus until it is taken; after a beat is
    // handed over, a random idle burst may follow.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            send_gap   <= 0;
        end else if (i_in_valid && o_in_stall) begin
            // Hold the stalled beat unchanged.
        end else if (send_gap != 0) begin
            send_gap   <= send_gap - 1;
            i_in_valid <= 1'b0;
        end else if (send_bytes.size() != 0) begin
            i_in_valid  <= 1'b1;
            i_text_byte <= send_bytes.pop_front();
            if (idle_on && $urandom_range(0, 9) == 0) begin
                send_gap <= $urandom_range(1, 18);
            end
        end else begin
            i_in_valid <= 1'b0;
        end
    end

    // Output stall generator. A toggle of long_hold_req starts a long hold that
    // this process counts down by itself; otherwise short random bursts.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            stall_left  <= 0;
        end else if (long_hold_req != long_hold_ack) begin
            long_hold_ack <= long_hold_req;
            stall_left    <= LONG_HOLD_CYCLES - 1;
            i_out_stall   <= 1'b1;
        end else if (stall_left != 0) begin
            stall_left  <= stall_left - 1;
            i_out_stall <= 1'b1;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            stall_left  <= $urandom_range(0, 17);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // Monitor and shadow parser in one process, so that the checks of one edge
    // always see the expectations queued at earlier edges.
    always @(posedge i_clk) begin : monitor
        t_color_result want;
        t_color_result next_result;
        bit            has_result;
        if (!i_rst_n) begin
            pmode     = PM_TEXT;
            code_acc  = 8'd0;
            code_seen = 1'b0;
            load_attr(ATTR_AT_RESET);
            color_expect.delete();
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (color_expect.size() == 0) begin
                    report_mismatch("result with nothing expected, char", o_out_char, 0);
                end else begin
                    want = color_expect.pop_front();
                    if (o_result_kind !== want.kind)
                        report_mismatch("result_kind", o_result_kind, want.kind);
                    if (o_out_char !== want.ch)
                        report_mismatch("out_char", o_out_char, want.ch);
                    if (o_fg_color !== want.fg)
                        report_mismatch("fg_color", o_fg_color, want.fg);
                    if (o_bg_color !== want.bg)
                        report_mismatch("bg_color", o_bg_color, want.bg);
                end
            end
            if (i_cfg_we) begin
                load_attr(i_cfg_wdata);
            end
            if (i_in_valid && !o_in_stall) begin
                predict_byte(i_text_byte, has_result, next_result);
                if (has_result) begin
                    color_expect.push_back(next_result);
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("ERROR: run exceeded %0d cycles", CYCLE_LIMIT);
            $display("ansi_sgr_color_parser_top: mismatch");
            $finish;
        end
    end

    // Waits until every queued byte has been taken and every expected result
    // has come back, then lets the pipeline empty out.
    task automatic wait_quiet();
        do @(negedge i_clk);
        while (send_bytes.size() != 0 || i_in_valid || color_expect.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_attr(input logic [7:0] attr);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= attr;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        @(negedge i_clk);
    endtask

    // Picks a color code: mostly from the four mapped ranges, sometimes any
    // byte value, sometimes a number large enough to saturate the accumulator.
    function automatic int pick_sgr_code();
        case ($urandom_range(0, 9))
            0, 1:    return 30 + $urandom_range(0, 7);
            2, 3:    return 90 + $urandom_range(0, 7);
            4, 5:    return 40 + $urandom_range(0, 7);
            6, 7:    return 100 + $urandom_range(0, 7);
            8:       return $urandom_range(0, 255);
            default: return $urandom_range(256, 9999);
        endcase
    endfunction

    // Queues a code as decimal digits, now and then with leading zeros.
    task automatic push_code(input int code);
        string digits;
        int    i;
        digits = $sformatf("%0d", code);
        if ($urandom_range(0, 7) == 0) begin
            digits = {"00", digits};
        end
        for (i = 0; i < digits.len(); i++) begin
            send_bytes.push_back(digits[i]);
        end
    endtask

    // Random text stream. Most of it is well-formed color sequences with
    // random codes and plain text around them; the rest is lone escapes,
    // sequences full of junk, and raw noise bytes. The stream stops once it
    // holds at least the requested number of bytes.
    task automatic queue_random_stream(input int n_bytes);
        int start;
        int pick;
        int n_part;
        int k;
        start = send_bytes.size();
        while (send_bytes.size() - start < n_bytes) begin
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                send_bytes.push_back(asgr_pkg::CH_ESC);
                send_bytes.push_back(asgr_pkg::CH_LBRACKET);
                n_part = $urandom_range(1, 3);
                for (k = 0; k < n_part; k++) begin
                    if (k != 0) send_bytes.push_back(asgr_pkg::CH_SEMI);
                    // An empty field gives a code of zero, or no digits at all.
                    if ($urandom_range(0, 15) != 0) push_code(pick_sgr_code());
                end
                send_bytes.push_back(asgr_pkg::CH_M);
            end else if (pick < 55) begin
                send_bytes.push_back(asgr_pkg::CH_ESC);
                send_bytes.push_back(8'($urandom_range(0, 255)));
            end else if (pick < 63) begin
                send_bytes.push_back(asgr_pkg::CH_ESC);
                send_bytes.push_back(asgr_pkg::CH_LBRACKET);
                n_part = $urandom_range(1, 5);
                for (k = 0; k < n_part; k++) begin
                    send_bytes.push_back(8'($urandom_range(0, 255)));
                end
                send_bytes.push_back(asgr_pkg::CH_M);
            end else if (pick < 75) begin
                send_bytes.push_back(8'($urandom_range(0, 255)));
            end else begin
                n_part = $urandom_range(1, 8);
                for (k = 0; k < n_part; k++) begin
                    send_bytes.push_back(8'($urandom_range(8'h20, 8'h7E)));
                end
            end
        end
    endtask

    // Stimulus sequence.
    initial begin : stimulus
        int i;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed bytes run with the attribute loaded at reset.
        @(negedge i_clk);
        foreach (DIRECTED_BYTES[i]) send_bytes.push_back(DIRECTED_BYTES[i]);
        wait_quiet();

        // Both attribute extremes first. The first random phase opens with a
        // long output hold while plain text keeps arriving, so the internal
        // queue fills and the input side has to stall.
        write_attr(8'h00);
        long_hold_req = ~long_hold_req;
        for (i = 0; i < 40; i++) send_bytes.push_back(8'($urandom_range(8'h20, 8'h7E)));
        queue_random_stream(136);
        wait_quiet();

        write_attr(8'hFF);
        queue_random_stream(136);
        wait_quiet();

        write_attr(8'($urandom_range(0, 255)));
        queue_random_stream(136);
        wait_quiet();

        write_attr(8'hF0);
        queue_random_stream(136);
        wait_quiet();

        // Last phase at full rate on both sides.
        write_attr(8'h5A);
        idle_on = 1'b0;
        queue_random_stream(136);
        wait_quiet();

        if (mismatch_count == 0) begin
            $display("ansi_sgr_color_parser_top: match");
        end else begin
            $display("ansi_sgr_color_parser_top: mismatch");
        end
        $finish;
    end

endmodule
